@@ rtl/core/wptc_pkg.sv @@
// Package for the waveform peak threshold counter core.
// Holds the field widths, stream byte widths, reset threshold and shared types.
// No dependencies.
package wptc_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 16;

  // Stream data widths, rounded up to whole bytes
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((COUNT_BITS + 7) / 8) * 8;

  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [IN_DATA_BITS-1:0]  in_data_t;
  typedef logic [OUT_DATA_BITS-1:0] out_data_t;

  // Threshold after reset, truncated to the sample width
  localparam sample_t THRESHOLD_RESET = sample_t'(7000);

  // Saturation value of the pulse count
  localparam count_t COUNT_MAX = '1;

endpackage

@@ rtl/core/waveform_peak_threshold_counter_core.sv @@
// Top level of the waveform peak threshold counter.
// Depends on wptc_pkg (widths, types, reset threshold).
//
// Usage:
//   in_*  : sample stream. in_tdata carries one sample, in_tlast closes the frame
//           (the sample carried with tlast is ignored, it only ends the frame).
//   out_* : one request per frame, sent when the tlast sample is processed.
//           out_tdata carries the pulse count, out_tuser the overflow flag.
//   cfg_* : threshold write port, always ready; write it only while idle.
// Throughput: one sample per cycle while no tlast waits on a busy result slot,
//   set by the single compare/count stage between the input register and the
//   state/result registers; an accepted tlast reaches out_tvalid via the result register.
// Reset (rst_n low, synchronous): threshold returns to 7000, frame state and
//   the valid flags of both pipeline registers are cleared.
// Stall: while out_tvalid is high and out_tready low, ordinary samples keep
//   flowing; a second tlast waits in the input register and then in_tready drops.
module waveform_peak_threshold_counter_core (
  input  logic                   clk,
  input  logic                   rst_n,
  // Sample stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  wptc_pkg::in_data_t     in_tdata,   // [23:0] sample
  input  logic                   in_tlast,
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output wptc_pkg::out_data_t    out_tdata,  // [15:0] pulse total
  output logic                   out_tuser,  // [0] overflow
  // Threshold write port
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  wptc_pkg::sample_t      cfg_data
);
  import wptc_pkg::*;

  // Threshold register
  sample_t thr_r;

  // Input register
  logic    s1_valid_r, s1_valid_nxt;
  sample_t s1_sample_r;
  logic    s1_last_r;
  logic    s1_adv;
  logic    in_acc;

  // Frame state
  sample_t older_r, older_nxt;
  sample_t cur_r, cur_nxt;
  logic    cur_valid_r, cur_valid_nxt;
  sample_t peak_r, peak_nxt;
  count_t  count_r, count_nxt;
  logic    sat_r, sat_nxt;

  // Result register
  logic    out_valid_r, out_valid_nxt;
  count_t  out_count_r;
  logic    out_ovf_r;
  logic    out_load;

  logic    is_peak, is_valley, hit;

  assign cfg_ready = 1'b1;

  // Input stage moves on unless it holds tlast and the result slot is busy
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = s1_adv && s1_last_r;

  always_comb begin
    s1_valid_nxt = in_acc || (s1_valid_r && !s1_adv);
  end

  // Peak / valley classification of the current level against its neighbors
  assign is_peak   = (older_r < cur_r) && (s1_sample_r < cur_r);
  assign is_valley = (cur_r < older_r) && (cur_r < s1_sample_r);
  assign hit       = is_valley && (peak_r >= thr_r) && (cur_r < thr_r);

  // Frame state update
  always_comb begin
    older_nxt     = older_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    peak_nxt      = peak_r;
    count_nxt     = count_r;
    sat_nxt       = sat_r;
    if (s1_adv) begin
      if (s1_last_r) begin
        older_nxt     = '0;
        cur_nxt       = '0;
        cur_valid_nxt = 1'b0;
        peak_nxt      = '0;
        count_nxt     = '0;
        sat_nxt       = 1'b0;
      end else if (!cur_valid_r) begin
        // first level that differs from the zero reference
        if (s1_sample_r != older_r) begin
          cur_nxt       = s1_sample_r;
          cur_valid_nxt = 1'b1;
        end
      end else if (s1_sample_r != cur_r) begin
        if (is_peak) begin
          peak_nxt = cur_r;
        end
        if (hit) begin
          if (count_r == COUNT_MAX) begin
            sat_nxt = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        older_nxt = cur_r;
        cur_nxt   = s1_sample_r;
      end
    end
  end

  // Result slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      older_r     <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      peak_r      <= '0;
      count_r     <= '0;
      sat_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      older_r     <= older_nxt;
      cur_r       <= cur_nxt;
      cur_valid_r <= cur_valid_nxt;
      peak_r      <= peak_nxt;
      count_r     <= count_nxt;
      sat_r       <= sat_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_tdata[SAMPLE_BITS-1:0];
      s1_last_r   <= in_tlast;
    end
    if (out_load) begin
      out_count_r <= count_r;
      out_ovf_r   <= sat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_BITS'(out_count_r);
  assign out_tuser  = out_ovf_r;

  // Checks
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (count_r == COUNT_MAX))
    else $error("saturated flag set with count below maximum");

  a_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !cur_valid_r |-> (older_r == '0))
    else $error("older level not zero before first level");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_tvalid && count_r == '0 && !sat_r && !cur_valid_r))
    else $error("frame state not cleared after result");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> ($stable(count_r) && $stable(cur_r) && $stable(peak_r)))
    else $error("frame state changed without a sample");

  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while a frame end is blocked");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for waveform_peak_threshold_counter_core.
// Drives sample frames and threshold writes, predicts pulse counts in a scoreboard class.
// Depends on wptc_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wptc_pkg::*;

  // Generous bound on the run length, even under heavy stalls
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int          RANDOM_ITEMS = 1250;
  localparam int          IDLE_PCT     = 36;

  typedef struct packed {
    count_t count;
    logic   overflow;
  } tally_t;

  // Predicts per-frame pulse counts and checks them against the result stream
  class pulse_tally_board;
    sample_t threshold;
    sample_t older_level;
    sample_t current_level;
    bit      current_valid;
    sample_t pending_peak;
    count_t  running_count;
    bit      saturated;
    tally_t  expected_q[$];
    int      errors;

    function new();
      threshold = THRESHOLD_RESET;
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      older_level   = '0;
      current_level = '0;
      current_valid = 1'b0;
      pending_peak  = '0;
      running_count = '0;
      saturated     = 1'b0;
    endfunction

    // Accepted sample request: update level tracking, queue a tally on tlast
    function void note_sample(sample_t s, bit is_last);
      if (is_last) begin
        expected_q.push_back(tally_t'{running_count, saturated});
        clear_frame();
        return;
      end
      if (!current_valid) begin
        // leading samples equal to the zero reference merge into it
        if (s != older_level) begin
          current_level = s;
          current_valid = 1'b1;
        end
      end else if (s != current_level) begin
        if (older_level < current_level && s < current_level) begin
          pending_peak = current_level;
        end else if (current_level < older_level && current_level < s &&
                     pending_peak >= threshold && current_level < threshold) begin
          if (running_count == COUNT_MAX) saturated = 1'b1;
          else running_count++;
        end
        older_level   = current_level;
        current_level = s;
      end
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(count_t count, logic overflow);
      tally_t want;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result count=%0d overflow=%0b", count, overflow));
        return;
      end
      want = expected_q.pop_front();
      if (count !== want.count)
        flag_mismatch($sformatf("pulse total got %0d want %0d", count, want.count));
      if (overflow !== want.overflow)
        flag_mismatch($sformatf("overflow got %0b want %0b", overflow, want.overflow));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  in_data_t   in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  out_data_t  out_tdata;
  logic       out_tuser;
  logic       cfg_valid;
  logic       cfg_ready;
  sample_t    cfg_data;

  pulse_tally_board board;
  bit               steady = 1'b0;   // no idling on either side while set
  int               items_sent = 0;
  int unsigned      cycles = 0;

  waveform_peak_threshold_counter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Result side: check accepted requests, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(count_t'(out_tdata[COUNT_BITS-1:0]), out_tuser);
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // One sample request; valid stays high unless an idle gap follows
  task automatic send_sample(sample_t s, bit is_last);
    in_tvalid <= 1'b1;
    in_tdata  <= in_data_t'(s);
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    board.note_sample(s, is_last);
    items_sent++;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Body samples then a closing tlast carrying a random (ignored) value
  task automatic send_frame(sample_t body[$]);
    foreach (body[i]) send_sample(body[i], 1'b0);
    send_sample(sample_t'($urandom), 1'b1);
  endtask

  // Hold off until every tally is back, plus the core's output latency
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(sample_t value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.threshold = value;
  endtask

  // Mostly alternating high/low runs around the threshold; some frames pure noise
  task automatic random_frame();
    sample_t body[$];
    sample_t thr;
    sample_t v;
    int      len;
    bit      high;
    bit      noise;
    thr   = board.threshold;
    noise = ($urandom_range(4) == 0);
    len   = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(20);
    high  = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (noise) begin
        v = sample_t'($urandom);
      end else begin
        case ($urandom_range(9))
          0: v = (body.size() != 0) ? body[$] : '0;   // extend a run
          1: begin
            case ($urandom_range(4))
              0: v = '0;
              1: v = '1;
              2: v = thr - 1'b1;
              3: v = thr;
              default: v = thr + 1'b1;
            endcase
          end
          default: begin
            if ($urandom_range(4) != 0) high = !high;
            if (high) v = sample_t'($urandom_range(thr, {SAMPLE_BITS{1'b1}}));
            else v = (thr == 0) ? '0 : sample_t'($urandom_range(0, thr - 1));
          end
        endcase
      end
      body.push_back(v);
    end
    send_frame(body);
  endtask

  initial begin
    sample_t body[$];
    sample_t phase_thr[6];
    board = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset threshold
    body = {};                                  // empty frame
    send_frame(body);
    body = {0, 0, 8000, 8000, 100, 9000};       // leading zeros, runs, ends rising
    send_frame(body);
    body = {7000, 6999, 7000};                  // peak exactly at threshold
    send_frame(body);
    body = {6999, 0};                           // peak short of threshold, ends falling
    send_frame(body);
    body = {9000, 7000, 9000, 24'hFFFFFF, 0, 24'hFFFFFF};  // valley at threshold, extremes
    send_frame(body);

    // Random phases across threshold settings, extremes included
    phase_thr[0] = '0;
    phase_thr[1] = '1;
    phase_thr[2] = sample_t'(1);
    phase_thr[3] = sample_t'($urandom);
    phase_thr[4] = sample_t'($urandom_range(1000, 20000));
    phase_thr[5] = THRESHOLD_RESET;
    items_sent = 0;
    for (int p = 0; p < 6; p++) begin
      write_threshold(phase_thr[p]);
      steady = (p == 3);
      while (items_sent < RANDOM_ITEMS * (p + 1) / 6) begin
        random_frame();
        if ($urandom_range(19) == 0) wait_drained();
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (board.expected_q.size() != 0)
      board.flag_mismatch($sformatf("%0d tallies never arrived", board.expected_q.size()));
    if (board.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
